### src/cle_pkg.sv
package cle_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int MODE_W   = 3;

  localparam logic [MODE_W-1:0] MODE_START  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_HEAD   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TAIL   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_AFTER  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DELETE = 3'd4;
  localparam logic [MODE_W-1:0] MODE_READ   = 3'd5;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic    capture;     // latch the input transaction
    logic    start;       // begin a one-element list
    logic    set_st;      // load the pending status code
    status_t st;
    logic    rd_tail;     // read the tail node
    logic    prime_ins;   // set up an insert after the tail
    logic    prime_walk;  // position the walk on the head
    logic    advance;     // step the walk to the next node
    logic    grab_ins;    // set up an insert after the current node
    logic    grab_del;    // set up unlinking of the current node
    logic    ins1;        // write the new node
    logic    ins2;        // relink its predecessor
    logic    del;         // unlink the current node
    logic    emit_elem;   // present a read-out element
    logic    emit_resp;   // present the status transaction
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic                empty;
    logic                full;
    logic                match;
    logic                last;
    logic                can_emit;
    logic [CNT_W-1:0]    count;
    logic [CAPACITY-1:0] in_use;
  } sts_t;

endpackage

### src/cle_ram.sv
module cle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/cle_dp.sv
module cle_dp import cle_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  input  logic [MODE_W-1:0]        mode,
  input  logic signed [DATA_W-1:0] value,
  input  logic signed [DATA_W-1:0] key,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] element,
  output logic [1:0]               status,
  output logic [CNT_W-1:0]         length,
  output logic                     final_res
);

  logic [MODE_W-1:0]   mode_r;
  logic [DATA_W-1:0]   value_r;
  logic [DATA_W-1:0]   key_r;
  logic [IDX_W-1:0]    tail;
  logic [CNT_W-1:0]    count;
  logic [CAPACITY-1:0] in_use;
  logic [IDX_W-1:0]    cur;
  logic [IDX_W-1:0]    prev;
  logic [CNT_W-1:0]    steps;
  logic [IDX_W-1:0]    p_slot;
  logic [IDX_W-1:0]    nl;
  logic [IDX_W-1:0]    t_slot;
  status_t             st_r;

  logic [IDX_W-1:0]  rd_addr;
  logic [DATA_W-1:0] value_q;
  logic [IDX_W-1:0]  link_q;
  logic              val_we;
  logic [IDX_W-1:0]  val_waddr;
  logic              lnk_we;
  logic [IDX_W-1:0]  lnk_waddr;
  logic [IDX_W-1:0]  lnk_wdata;
  logic [IDX_W-1:0]  free_slot;
  logic              can_emit;
  logic              last;

  // lowest free slot
  always_comb begin
    free_slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_slot = IDX_W'(i);
      end
    end
  end

  assign can_emit = !out_valid || out_ready;
  assign last     = (steps + CNT_W'(1)) == count;

  always_comb begin
    if (cmd.rd_tail) begin
      rd_addr = tail;
    end else if (cmd.prime_walk || cmd.advance) begin
      rd_addr = link_q;
    end else begin
      rd_addr = cur;
    end
  end

  assign val_we    = cmd.start || cmd.ins1;
  assign val_waddr = cmd.start ? '0 : t_slot;
  assign lnk_we    = cmd.start || cmd.ins1 || cmd.ins2 || cmd.del;

  always_comb begin
    if (cmd.start) begin
      lnk_waddr = '0;
      lnk_wdata = '0;
    end else if (cmd.ins1) begin
      lnk_waddr = t_slot;
      lnk_wdata = nl;
    end else if (cmd.ins2) begin
      lnk_waddr = p_slot;
      lnk_wdata = t_slot;
    end else begin
      lnk_waddr = p_slot;
      lnk_wdata = nl;
    end
  end

  cle_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_values (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (value_r),
    .raddr (rd_addr),
    .rdata (value_q)
  );

  cle_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_links (
    .clk   (clk),
    .we    (lnk_we),
    .waddr (lnk_waddr),
    .wdata (lnk_wdata),
    .raddr (rd_addr),
    .rdata (link_q)
  );

  // operand and walk registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r  <= mode;
      value_r <= value;
      key_r   <= key;
    end
    if (cmd.set_st) begin
      st_r <= cmd.st;
    end
    if (cmd.prime_walk) begin
      cur   <= link_q;
      prev  <= tail;
      steps <= '0;
    end else if (cmd.advance) begin
      cur   <= link_q;
      prev  <= cur;
      steps <= steps + CNT_W'(1);
    end
    if (cmd.prime_ins || cmd.grab_ins) begin
      p_slot <= cmd.prime_ins ? tail : cur;
      nl     <= link_q;
      t_slot <= free_slot;
    end else if (cmd.grab_del) begin
      p_slot <= prev;
      nl     <= link_q;
    end
  end

  // list bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      tail   <= '0;
      count  <= '0;
      in_use <= '0;
    end else if (cmd.start) begin
      tail   <= '0;
      count  <= CNT_W'(1);
      in_use <= CAPACITY'(1);
    end else if (cmd.ins2) begin
      in_use[t_slot] <= 1'b1;
      count          <= count + CNT_W'(1);
      if (mode_r == MODE_TAIL || (mode_r == MODE_AFTER && p_slot == tail)) begin
        tail <= t_slot;
      end
    end else if (cmd.del) begin
      if (count == CNT_W'(1)) begin
        tail   <= '0;
        count  <= '0;
        in_use <= '0;
      end else begin
        in_use[cur] <= 1'b0;
        count       <= count - CNT_W'(1);
        if (cur == tail) begin
          tail <= prev;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_elem || cmd.emit_resp) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_elem) begin
      element   <= value_q;
      status    <= ST_OK;
      length    <= count;
      final_res <= last;
    end else if (cmd.emit_resp) begin
      element   <= '0;
      status    <= st_r;
      length    <= count;
      final_res <= 1'b1;
    end
  end

  always_comb begin
    sts.mode     = mode_r;
    sts.empty    = count == '0;
    sts.full     = count >= CNT_W'(CAPACITY);
    sts.match    = value_q == ((mode_r == MODE_AFTER) ? key_r : value_r);
    sts.last     = last;
    sts.can_emit = can_emit;
    sts.count    = count;
    sts.in_use   = in_use;
  end

endmodule

### src/cle_ctrl.sv
module cle_ctrl import cle_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DISP  = 9'b000000010,
    S_FETCH = 9'b000000100,
    S_PRIME = 9'b000001000,
    S_WALK  = 9'b000010000,
    S_INS1  = 9'b000100000,
    S_INS2  = 9'b001000000,
    S_DEL   = 9'b010000000,
    S_RESP  = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd        = '0;
    cmd.st     = ST_OK;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISP;
        end
      end
      S_DISP: begin
        state_next = S_FETCH;
        case (sts.mode)
          MODE_START: begin
            cmd.start  = 1'b1;
            cmd.set_st = 1'b1;
            state_next = S_RESP;
          end
          MODE_HEAD, MODE_TAIL: begin
            if (sts.empty) begin
              cmd.start  = 1'b1;
              cmd.set_st = 1'b1;
              state_next = S_RESP;
            end else if (sts.full) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_FULL;
              state_next = S_RESP;
            end
          end
          MODE_AFTER: begin
            if (sts.empty) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_EMPTY;
              state_next = S_RESP;
            end else if (sts.full) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_FULL;
              state_next = S_RESP;
            end
          end
          MODE_DELETE, MODE_READ: begin
            if (sts.empty) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_EMPTY;
              state_next = S_RESP;
            end
          end
          default: begin
            cmd.set_st = 1'b1;
            state_next = S_RESP;
          end
        endcase
      end
      S_FETCH: begin
        cmd.rd_tail = 1'b1;
        state_next  = S_PRIME;
      end
      S_PRIME: begin
        if (sts.mode == MODE_HEAD || sts.mode == MODE_TAIL) begin
          cmd.prime_ins = 1'b1;
          state_next    = S_INS1;
        end else begin
          cmd.prime_walk = 1'b1;
          state_next     = S_WALK;
        end
      end
      S_WALK: begin
        if (sts.mode == MODE_READ) begin
          if (sts.can_emit) begin
            cmd.emit_elem = 1'b1;
            if (sts.last) begin
              state_next = S_IDLE;
            end else begin
              cmd.advance = 1'b1;
            end
          end
        end else if (sts.match) begin
          if (sts.mode == MODE_AFTER) begin
            cmd.grab_ins = 1'b1;
            state_next   = S_INS1;
          end else begin
            cmd.grab_del = 1'b1;
            state_next   = S_DEL;
          end
        end else if (sts.last) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_NOTFOUND;
          state_next = S_RESP;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      S_INS1: begin
        cmd.ins1   = 1'b1;
        state_next = S_INS2;
      end
      S_INS2: begin
        cmd.ins2   = 1'b1;
        cmd.set_st = 1'b1;
        state_next = S_RESP;
      end
      S_DEL: begin
        cmd.del    = 1'b1;
        cmd.set_st = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (sts.can_emit) begin
          cmd.emit_resp = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### src/circular_list_engine_unit.sv
// Circular singly linked list of signed 32-bit values held in a store of
// CAPACITY (32) nodes, with the head being the node after the tail. Each
// input transaction names one operation by mode: start a new list, insert
// at head or tail, insert after the first node equal to key, delete the
// first node equal to value, or read the list out. A read-out returns one
// output transaction per element from head to tail, final_res marking the
// last; every other operation returns a single status transaction (ok, not
// found, full, empty) with length giving the element count afterwards.
// New nodes take the lowest free slot. One operation is in flight at a
// time, and search or read-out walks the linked nodes at one node per
// cycle through the registered-read node store, a read-out only while
// the output is not stalled. A new transaction is taken while the last
// result still waits in the output register. After reset the list is
// empty and ready at once.
module circular_list_engine_unit import cle_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [MODE_W-1:0]        mode,
  input  logic signed [DATA_W-1:0] value,
  input  logic signed [DATA_W-1:0] key,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] element,
  output logic [1:0]               status,
  output logic [CNT_W-1:0]         length,
  output logic                     final_res
);

  cmd_t cmd;
  sts_t sts;

  // sequencing of each operation
  cle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // node store, list registers and output register
  cle_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .mode      (mode),
    .value     (value),
    .key       (key),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .element   (element),
    .status    (status),
    .length    (length),
    .final_res (final_res)
  );

  // the occupancy mask and the element count must always agree
  a_count_matches_slots: assert property (@(posedge clk) disable iff (rst)
    $countones(sts.in_use) == 32'(sts.count))
    else $error("slot mask and element count disagree");

  // hold off new transactions while an operation is in flight
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transaction accepted during an operation");

  // drop element data on every non-ok status
  a_elem_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> element == '0)
    else $error("element set on a status transaction");

  // never exceed the store capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.ins2 |-> !sts.full)
    else $error("insert into a full store");

endmodule

### sim/list_check.sv
`timescale 1ns / 100ps
module list_check import cle_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [MODE_W-1:0]        mode,
  input  logic signed [DATA_W-1:0] value,
  input  logic signed [DATA_W-1:0] key,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic signed [DATA_W-1:0] element,
  input  logic [1:0]               status,
  input  logic [CNT_W-1:0]         length,
  input  logic                     final_res,
  output int                       mismatch_count,
  output int                       results_pending
);

  typedef struct {
    logic signed [DATA_W-1:0] elem;
    status_t                  st;
    logic [CNT_W-1:0]         len;
    logic                     last;
  } list_result_t;

  list_result_t awaited_results[$];

  // mirror of the node store
  logic signed [DATA_W-1:0] node_val [CAPACITY];
  logic [IDX_W-1:0]         node_nxt [CAPACITY];
  logic [IDX_W-1:0]         tail_idx;
  int                       live_count;
  logic [CAPACITY-1:0]      used;

  task automatic report_mismatch(string what);
    $display("%0t: result mismatch, %s", $time, what);
    mismatch_count++;
  endtask

  function automatic void push_result(logic signed [DATA_W-1:0] el, status_t st, logic last);
    list_result_t r;
    r.elem = el;
    r.st   = st;
    r.len  = CNT_W'(live_count);
    r.last = last;
    awaited_results.push_back(r);
  endfunction

  function automatic void begin_list(logic signed [DATA_W-1:0] v);
    used        = '0;
    used[0]     = 1'b1;
    node_val[0] = v;
    node_nxt[0] = '0;
    tail_idx    = '0;
    live_count  = 1;
  endfunction

  // Link v after slot p in the lowest free slot; the caller guarantees one is free.
  function automatic logic [IDX_W-1:0] attach_after(logic [IDX_W-1:0] p,
                                                    logic signed [DATA_W-1:0] v);
    logic [IDX_W-1:0] t;
    t = '0;
    for (int i = CAPACITY - 1; i >= 0; i--)
      if (!used[i]) t = IDX_W'(i);
    node_val[t] = v;
    node_nxt[t] = node_nxt[p];
    node_nxt[p] = t;
    used[t]     = 1'b1;
    live_count++;
    return t;
  endfunction

  function automatic void mirror_op(logic [MODE_W-1:0] m, logic signed [DATA_W-1:0] v,
                                    logic signed [DATA_W-1:0] k);
    status_t          st;
    logic [IDX_W-1:0] prev;
    logic [IDX_W-1:0] cur;
    bit               hit;
    st  = ST_OK;
    hit = 1'b0;
    case (m)
      MODE_START: begin_list(v);
      MODE_HEAD, MODE_TAIL: begin
        if (live_count == 0) begin
          begin_list(v);
        end else if (live_count >= CAPACITY) begin
          st = ST_FULL;
        end else begin
          cur = attach_after(tail_idx, v);
          if (m == MODE_TAIL) tail_idx = cur;
        end
      end
      MODE_AFTER: begin
        if (live_count == 0) begin
          st = ST_EMPTY;
        end else if (live_count >= CAPACITY) begin
          st = ST_FULL;
        end else begin
          cur = node_nxt[tail_idx];
          for (int i = 0; i < live_count && !hit; i++) begin
            if (node_val[cur] == k) begin
              hit  = 1'b1;
              prev = attach_after(cur, v);
              if (cur == tail_idx) tail_idx = prev;
            end else begin
              cur = node_nxt[cur];
            end
          end
          if (!hit) st = ST_NOTFOUND;
        end
      end
      MODE_DELETE: begin
        if (live_count == 0) begin
          st = ST_EMPTY;
        end else begin
          prev = tail_idx;
          cur  = node_nxt[prev];
          for (int i = 0; i < live_count && !hit; i++) begin
            if (node_val[cur] == v) begin
              hit = 1'b1;
              if (live_count == 1) begin
                used       = '0;
                live_count = 0;
                tail_idx   = '0;
              end else begin
                node_nxt[prev] = node_nxt[cur];
                if (cur == tail_idx) tail_idx = prev;
                used[cur] = 1'b0;
                live_count--;
              end
            end else begin
              prev = cur;
              cur  = node_nxt[cur];
            end
          end
          if (!hit) st = ST_NOTFOUND;
        end
      end
      MODE_READ: begin
        if (live_count == 0) begin
          push_result('0, ST_EMPTY, 1'b1);
        end else begin
          cur = node_nxt[tail_idx];
          for (int i = 0; i < live_count; i++) begin
            push_result(node_val[cur], ST_OK, i == live_count - 1);
            cur = node_nxt[cur];
          end
        end
        return;
      end
      default: ;
    endcase
    push_result('0, st, 1'b1);
  endfunction

  task automatic check_result();
    list_result_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch($sformatf(
        "unexpected transaction: element %0d status %0d length %0d final %0b",
        element, status, length, final_res));
      return;
    end
    want = awaited_results.pop_front();
    if (element !== want.elem)
      report_mismatch($sformatf("element %0d, expected %0d", element, want.elem));
    if (status !== want.st)
      report_mismatch($sformatf("status %0d, expected %s", status, want.st.name()));
    if (length !== want.len)
      report_mismatch($sformatf("length %0d, expected %0d", length, want.len));
    if (final_res !== want.last)
      report_mismatch($sformatf("final_res %0b, expected %0b", final_res, want.last));
  endtask

  // Check the outgoing transaction first: it always belongs to an earlier input.
  always @(posedge clk) begin
    if (rst) begin
      awaited_results.delete();
      mismatch_count = 0;
      used           = '0;
      live_count     = 0;
      tail_idx       = '0;
    end else begin
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) mirror_op(mode, value, key);
    end
    results_pending = awaited_results.size();
  end

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
module testbench import cle_pkg::*; ();

  // modes with no operation behind them
  localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;

  localparam logic signed [DATA_W-1:0] MAX_VAL = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] MIN_VAL = 32'sh8000_0000;

  // receiver hold-off length, long enough for a full read-out to back up
  localparam int HOLD_CYCLES = 300;

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  logic [MODE_W-1:0]        mode      = '0;
  logic signed [DATA_W-1:0] value     = '0;
  logic signed [DATA_W-1:0] key       = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] element;
  logic [1:0]               status;
  logic [CNT_W-1:0]         length;
  logic                     final_res;

  int mismatch_count;
  int results_pending;

  // idling odds of the current phase, in percent
  int idle_pct  = 0;
  int stall_pct = 0;

  // hold-off requests from the stimulus, served by the receiver process
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  // values that were offered for insertion, to aim keys and deletes at real nodes
  logic signed [DATA_W-1:0] seen_values[$];

  circular_list_engine_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .value     (value),
    .key       (key),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .element   (element),
    .status    (status),
    .length    (length),
    .final_res (final_res)
  );

  list_check checker_inst (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .mode            (mode),
    .value           (value),
    .key             (key),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .element         (element),
    .status          (status),
    .length          (length),
    .final_res       (final_res),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  always #5 clk = ~clk;

  // Hard stop: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  // Receiver: stall at random, or hold off completely while a request is served.
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready = 1'b0;
    end else begin
      out_ready = ($urandom_range(99) >= stall_pct);
    end
  end

  // Mix full-range values with a small range, so that duplicates and key hits occur.
  function automatic logic signed [DATA_W-1:0] fresh_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(9))
      0: v = MAX_VAL;
      1: v = MIN_VAL;
      2, 3, 4: begin
        v = $urandom_range(15);
        v = v - 8;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Mostly a value already offered, sometimes a fresh one that may miss.
  function automatic logic signed [DATA_W-1:0] known_value();
    if (seen_values.size() == 0 || $urandom_range(3) == 0) return fresh_value();
    return seen_values[$urandom_range(seen_values.size() - 1)];
  endfunction

  // Offer one input transaction and hold it until accepted. Idle first at the
  // phase's odds; valid stays high straight into the next transaction otherwise.
  task automatic send_op(logic [MODE_W-1:0] m, logic signed [DATA_W-1:0] v,
                         logic signed [DATA_W-1:0] k);
    int hit;
    hit = -1;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    mode     = m;
    value    = v;
    key      = k;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    // track what the list probably holds
    case (m)
      MODE_START: begin
        seen_values.delete();
        seen_values.push_back(v);
      end
      MODE_HEAD, MODE_TAIL, MODE_AFTER: seen_values.push_back(v);
      MODE_DELETE: begin
        foreach (seen_values[i])
          if (hit < 0 && seen_values[i] == v) hit = i;
        if (hit >= 0) seen_values.delete(hit);
      end
      default: ;
    endcase
  endtask

  // One random operation, weighted toward inserts and hits on existing nodes.
  task automatic random_op();
    int                       pick;
    logic [MODE_W-1:0]        m;
    logic signed [DATA_W-1:0] v;
    logic signed [DATA_W-1:0] k;
    pick = $urandom_range(99);
    v    = fresh_value();
    k    = fresh_value();
    if (pick < 4) begin
      m = MODE_START;
    end else if (pick < 22) begin
      m = MODE_TAIL;
    end else if (pick < 38) begin
      m = MODE_HEAD;
    end else if (pick < 58) begin
      m = MODE_AFTER;
      k = known_value();
    end else if (pick < 78) begin
      m = MODE_DELETE;
      v = known_value();
    end else if (pick < 94) begin
      m = MODE_READ;
    end else begin
      m = pick[0] ? MODE_SPARE_A : MODE_SPARE_B;
    end
    send_op(m, v, k);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty list: read-out, delete and insert-after all report empty.
    send_op(MODE_READ, fresh_value(), fresh_value());
    send_op(MODE_DELETE, 32'sd1, fresh_value());
    send_op(MODE_AFTER, 32'sd2, 32'sd1);
    // Insert at head of an empty list starts it; deleting the only node empties it.
    send_op(MODE_HEAD, MAX_VAL, MIN_VAL);
    send_op(MODE_DELETE, MAX_VAL, MAX_VAL);
    // Insert at tail of an empty list starts it too.
    send_op(MODE_TAIL, MIN_VAL, MAX_VAL);
    send_op(MODE_HEAD, 32'sd0, 32'sd0);
    send_op(MODE_TAIL, -32'sd1, -32'sd1);
    send_op(MODE_AFTER, 32'sd5, MIN_VAL);
    // Insert after the tail moves the tail.
    send_op(MODE_AFTER, 32'sh5555_5555, -32'sd1);
    send_op(MODE_AFTER, 32'sd9, 32'sh1234_5678);
    send_op(MODE_DELETE, 32'sh1234_5678, 32'sd0);
    send_op(MODE_READ, 32'sd0, 32'sd0);
    // Delete the tail, then the head.
    send_op(MODE_DELETE, 32'sh5555_5555, 32'sd0);
    send_op(MODE_DELETE, 32'sd0, 32'sd0);
    send_op(MODE_READ, MAX_VAL, MIN_VAL);
    send_op(MODE_SPARE_A, MAX_VAL, MAX_VAL);
    send_op(MODE_SPARE_B, MIN_VAL, MIN_VAL);
    // Start over, add a duplicate and drop the first of the two.
    send_op(MODE_START, 32'shAAAA_AAAA, 32'sh5555_5555);
    send_op(MODE_TAIL, 32'sh3333_3333, 32'sd0);
    send_op(MODE_TAIL, 32'shAAAA_AAAA, 32'sd0);
    send_op(MODE_DELETE, 32'shAAAA_AAAA, 32'sd0);
    send_op(MODE_READ, 32'sd0, 32'sd0);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 74; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 74; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      if (p == 0) begin
        // Fill the store: the last two head or tail inserts and the insert-after
        // are refused as full, then free a few slots and refill the holes.
        send_op(MODE_START, fresh_value(), fresh_value());
        repeat (CAPACITY + 1)
          send_op($urandom_range(1) ? MODE_HEAD : MODE_TAIL, fresh_value(), fresh_value());
        send_op(MODE_AFTER, fresh_value(), known_value());
        send_op(MODE_READ, fresh_value(), fresh_value());
        repeat (3) send_op(MODE_DELETE, known_value(), fresh_value());
        repeat (3) send_op(MODE_AFTER, fresh_value(), known_value());
        send_op(MODE_READ, fresh_value(), fresh_value());
      end
      repeat (23) random_op();
    end

    // Back-pressure: build a list, hold the receiver off and keep offering
    // read-outs until the block stalls its input.
    idle_pct  = 0;
    stall_pct = 0;
    send_op(MODE_START, fresh_value(), fresh_value());
    repeat (12) send_op(MODE_TAIL, fresh_value(), fresh_value());
    hold_requests++;
    repeat (4) send_op(MODE_READ, fresh_value(), fresh_value());
    repeat (4) random_op();

    @(negedge clk);
    in_valid = 1'b0;

    // Drain, then give the block time to show any stray transaction.
    while (results_pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);

    if (mismatch_count == 0 && results_pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

### circular_list_engine_unit.f
src/cle_pkg.sv
src/cle_ram.sv
src/cle_dp.sv
src/cle_ctrl.sv
src/circular_list_engine_unit.sv
sim/list_check.sv
sim/testbench.sv
